### rtl/swc_pkg.sv
// shared types, constants and helpers of the spring column water surface
`default_nettype none
package swc_pkg;

    localparam int RESOLUTION_DEF    = 16;
    localparam int SPREAD_PASSES_DEF = 8;
    localparam int VAL_W     = 24;
    localparam int COL_W     = 6;
    localparam int COL_OUT_W = 5;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    localparam logic signed [23:0] REST_HEIGHT_RST  = 24'sd0;
    localparam logic signed [23:0] LEFT_EDGE_RST    = -24'sd65536;
    localparam logic        [22:0] COLUMN_WIDTH_RST = 23'd8192;
    localparam logic        [15:0] SPRING_GAIN_RST  = 16'd1638;
    localparam logic        [15:0] DAMPING_GAIN_RST = 16'd1638;
    localparam logic        [15:0] SPREAD_GAIN_RST  = 16'd2621;
    localparam logic signed [23:0] SPLASH_SPEED_RST = 24'sd6554;

    typedef enum logic [2:0] {
        REG_REST_HEIGHT  = 3'd0,
        REG_LEFT_EDGE    = 3'd1,
        REG_COLUMN_WIDTH = 3'd2,
        REG_SPRING_GAIN  = 3'd3,
        REG_DAMPING_GAIN = 3'd4,
        REG_SPREAD_GAIN  = 3'd5,
        REG_SPLASH_SPEED = 3'd6,
        REG_NONE         = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [23:0] rest_height;
        logic signed [23:0] left_edge;
        logic        [22:0] column_width;
        logic        [15:0] spring_gain;
        logic        [15:0] damping_gain;
        logic        [15:0] spread_gain;
        logic signed [23:0] splash_speed;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_READ,
        OP_S1_LD,
        OP_S1_MS,
        OP_S1_MD,
        OP_S1_WR,
        OP_SP_HC,
        OP_SP_LD,
        OP_SP_ML,
        OP_SP_MR,
        OP_SP_WR,
        OP_EMIT,
        OP_HIT_INIT,
        OP_HIT_STEP,
        OP_HIT_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t           op;
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] ha;
        logic             first;
        logic             right;
        logic             last;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic hit_done;
    } dp_stat_t;

    function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
        logic signed [23:0] r;
        if (v > 28'sd8388607)
        begin
            r = 24'sh7FFFFF;
        end
        else if (v < -28'sd8388608)
        begin
            r = 24'sh800000;
        end
        else
        begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/swc_cfg.sv
// register file behind the configuration port
`default_nettype none
module swc_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [swc_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [swc_pkg::DATA_W-1:0]    pwdata,
    output logic      [swc_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    output swc_pkg::cfg_t                      cfg
);

    swc_pkg::cfg_t    cfg_reg;
    swc_pkg::reg_idx_t idx;

    assign idx    = swc_pkg::reg_idx_t'(paddr[4:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rest_height  <= swc_pkg::REST_HEIGHT_RST;
            cfg_reg.left_edge    <= swc_pkg::LEFT_EDGE_RST;
            cfg_reg.column_width <= swc_pkg::COLUMN_WIDTH_RST;
            cfg_reg.spring_gain  <= swc_pkg::SPRING_GAIN_RST;
            cfg_reg.damping_gain <= swc_pkg::DAMPING_GAIN_RST;
            cfg_reg.spread_gain  <= swc_pkg::SPREAD_GAIN_RST;
            cfg_reg.splash_speed <= swc_pkg::SPLASH_SPEED_RST;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                swc_pkg::REG_REST_HEIGHT:  cfg_reg.rest_height  <= pwdata[23:0];
                swc_pkg::REG_LEFT_EDGE:    cfg_reg.left_edge    <= pwdata[23:0];
                swc_pkg::REG_COLUMN_WIDTH: cfg_reg.column_width <= pwdata[22:0];
                swc_pkg::REG_SPRING_GAIN:  cfg_reg.spring_gain  <= pwdata[15:0];
                swc_pkg::REG_DAMPING_GAIN: cfg_reg.damping_gain <= pwdata[15:0];
                swc_pkg::REG_SPREAD_GAIN:  cfg_reg.spread_gain  <= pwdata[15:0];
                swc_pkg::REG_SPLASH_SPEED: cfg_reg.splash_speed <= pwdata[23:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            swc_pkg::REG_REST_HEIGHT:  prdata = 32'(unsigned'(cfg_reg.rest_height));
            swc_pkg::REG_LEFT_EDGE:    prdata = 32'(unsigned'(cfg_reg.left_edge));
            swc_pkg::REG_COLUMN_WIDTH: prdata = 32'(cfg_reg.column_width);
            swc_pkg::REG_SPRING_GAIN:  prdata = 32'(cfg_reg.spring_gain);
            swc_pkg::REG_DAMPING_GAIN: prdata = 32'(cfg_reg.damping_gain);
            swc_pkg::REG_SPREAD_GAIN:  prdata = 32'(cfg_reg.spread_gain);
            swc_pkg::REG_SPLASH_SPEED: prdata = 32'(unsigned'(cfg_reg.splash_speed));
            default:                   prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

### rtl/swc_ctrl.sv
// sequencer that steps the datapath through ticks, emission and hit tests
`default_nettype none
module swc_ctrl #(
    parameter int RESOLUTION    = swc_pkg::RESOLUTION_DEF,
    parameter int SPREAD_PASSES = swc_pkg::SPREAD_PASSES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    input  wire logic               s_tuser,
    output logic                    s_tready,
    input  wire swc_pkg::dp_stat_t  stat,
    output swc_pkg::dp_cmd_t        cmd
);

    localparam int NCOL = RESOLUTION + 1;
    localparam int IW   = $clog2(NCOL);
    localparam int PW   = $clog2(SPREAD_PASSES + 1);

    typedef enum logic [4:0] {
        IDLE, S1_RD, S1_LD, S1_MS, S1_MD, S1_WR,
        SP_RD0, SP_HC, SP_RD, SP_LD, SP_ML, SP_MR, SP_WR,
        EM_RD, EM_OUT, H_INIT, H_STEP, H_OUT
    } state_t;

    state_t          state_reg;
    logic [IW-1:0]   j_reg;
    logic [PW-1:0]   pass_reg;
    logic            j_last;
    logic            pass_last;

    assign j_last    = (j_reg == IW'(RESOLUTION));
    assign pass_last = (pass_reg == PW'(SPREAD_PASSES - 1));
    assign s_tready  = (state_reg == IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            j_reg     <= '0;
            pass_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                IDLE:
                begin
                    if (s_tvalid)
                    begin
                        j_reg     <= '0;
                        pass_reg  <= '0;
                        state_reg <= s_tuser ? H_INIT : S1_RD;
                    end
                end
                S1_RD: state_reg <= S1_LD;
                S1_LD: state_reg <= S1_MS;
                S1_MS: state_reg <= S1_MD;
                S1_MD: state_reg <= S1_WR;
                S1_WR:
                begin
                    if (j_last)
                    begin
                        j_reg     <= '0;
                        state_reg <= SP_RD0;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S1_RD;
                    end
                end
                SP_RD0: state_reg <= SP_HC;
                SP_HC:  state_reg <= SP_RD;
                SP_RD:  state_reg <= SP_LD;
                SP_LD:  state_reg <= SP_ML;
                SP_ML:  state_reg <= SP_MR;
                SP_MR:  state_reg <= SP_WR;
                SP_WR:
                begin
                    if (j_last)
                    begin
                        j_reg <= '0;
                        if (pass_last)
                        begin
                            state_reg <= EM_RD;
                        end
                        else
                        begin
                            pass_reg  <= pass_reg + 1'b1;
                            state_reg <= SP_RD0;
                        end
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= SP_RD;
                    end
                end
                EM_RD: state_reg <= EM_OUT;
                EM_OUT:
                begin
                    if (stat.out_free)
                    begin
                        if (j_last)
                        begin
                            state_reg <= IDLE;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= EM_RD;
                        end
                    end
                end
                H_INIT: state_reg <= H_STEP;
                H_STEP:
                begin
                    if (stat.hit_done)
                    begin
                        state_reg <= H_OUT;
                    end
                end
                H_OUT:
                begin
                    if (stat.out_free)
                    begin
                        state_reg <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd       = '0;
        cmd.op    = swc_pkg::OP_NOP;
        cmd.col   = swc_pkg::COL_W'(j_reg);
        cmd.ha    = swc_pkg::COL_W'(j_reg);
        cmd.first = (j_reg == '0);
        cmd.right = j_last;
        cmd.last  = j_last;
        unique case (state_reg)
            IDLE:   cmd.op = s_tvalid ? swc_pkg::OP_CAPTURE : swc_pkg::OP_NOP;
            S1_RD:  cmd.op = swc_pkg::OP_READ;
            S1_LD:  cmd.op = swc_pkg::OP_S1_LD;
            S1_MS:  cmd.op = swc_pkg::OP_S1_MS;
            S1_MD:  cmd.op = swc_pkg::OP_S1_MD;
            S1_WR:  cmd.op = swc_pkg::OP_S1_WR;
            SP_RD0:
            begin
                cmd.op = swc_pkg::OP_READ;
                cmd.ha = '0;
            end
            SP_HC:  cmd.op = swc_pkg::OP_SP_HC;
            SP_RD:
            begin
                // right neighbor of column j; the last column has none
                cmd.op = swc_pkg::OP_READ;
                cmd.ha = j_last ? swc_pkg::COL_W'(j_reg) : swc_pkg::COL_W'(j_reg + 1'b1);
            end
            SP_LD:  cmd.op = swc_pkg::OP_SP_LD;
            SP_ML:  cmd.op = swc_pkg::OP_SP_ML;
            SP_MR:  cmd.op = swc_pkg::OP_SP_MR;
            SP_WR:  cmd.op = swc_pkg::OP_SP_WR;
            EM_RD:  cmd.op = swc_pkg::OP_READ;
            EM_OUT: cmd.op = stat.out_free ? swc_pkg::OP_EMIT : swc_pkg::OP_NOP;
            H_INIT: cmd.op = swc_pkg::OP_HIT_INIT;
            H_STEP: cmd.op = stat.hit_done ? swc_pkg::OP_NOP : swc_pkg::OP_HIT_STEP;
            H_OUT:  cmd.op = stat.out_free ? swc_pkg::OP_HIT_OUT : swc_pkg::OP_NOP;
            default: cmd.op = swc_pkg::OP_NOP;
        endcase
    end

    a_last_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == swc_pkg::OP_EMIT && cmd.last) |=> state_reg == IDLE)
        else $error("last height emitted but sequencer kept running");

    a_pass_range: assert property (@(posedge clk) disable iff (!rst_n)
        pass_reg < PW'(SPREAD_PASSES))
        else $error("spreading pass counter out of range");

    a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != IDLE) |-> cmd.op != swc_pkg::OP_CAPTURE)
        else $error("input captured while busy");

endmodule
`default_nettype wire

### rtl/swc_dp.sv
// column memories, shared multiplier, hit search and output register
`default_nettype none
module swc_dp #(
    parameter int RESOLUTION = swc_pkg::RESOLUTION_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire swc_pkg::cfg_t     cfg,
    input  wire swc_pkg::dp_cmd_t  cmd,
    output swc_pkg::dp_stat_t      stat,
    input  wire logic [47:0]       s_tdata,
    output logic [31:0]            m_tdata,
    output logic                   m_tuser,
    output logic                   m_tlast,
    output logic                   m_tvalid,
    input  wire logic              m_tready
);

    localparam int NCOL = RESOLUTION + 1;
    localparam int IW   = $clog2(NCOL);

    logic signed [23:0] hmem [NCOL];
    logic signed [23:0] vmem [NCOL];
    logic [NCOL-1:0]    hval_reg;
    logic [NCOL-1:0]    vval_reg;

    logic signed [23:0] h_rd_reg, v_rd_reg;
    logic               hv_rd_reg, vv_rd_reg;
    logic signed [23:0] hdat, vdat;

    logic signed [23:0] obj_x_reg, obj_y_reg;
    logic signed [23:0] hp_reg, hc_reg, hn_reg, vc_reg, ht_reg, vt_reg;
    logic signed [24:0] dl_reg, dr_reg, mul_reg, p1_reg;

    logic        [15:0] mul_gain;
    logic signed [24:0] mul_b;
    logic signed [41:0] prod;

    logic [23:0]        rem_reg;
    logic [IW-1:0]      hcol_reg;
    logic               hit_done_reg, struck_reg;
    logic signed [24:0] hit_diff;

    logic               we;
    logic               h_we;
    logic [IW-1:0]      wa;
    logic signed [23:0] h_wd, v_wd;
    logic signed [26:0] accel;
    logic signed [23:0] ht_next, vt_next;

    logic               load;
    logic [IW+4:0]      col_ext;
    logic [4:0]         out_col;
    logic signed [23:0] out_height;
    logic               out_hit;

    logic               out_valid_reg;
    logic signed [23:0] out_height_reg;
    logic [4:0]         out_col_reg;
    logic               out_hit_reg, out_last_reg;

    assign hdat = hv_rd_reg ? h_rd_reg : 24'sd0;
    assign vdat = vv_rd_reg ? v_rd_reg : 24'sd0;

    // shared gain multiplier, floor of product over 2^16
    always_comb
    begin
        unique case (cmd.op)
            swc_pkg::OP_S1_MS:
            begin
                mul_gain = cfg.spring_gain;
                mul_b    = dl_reg;
            end
            swc_pkg::OP_S1_MD:
            begin
                mul_gain = cfg.damping_gain;
                mul_b    = 25'(vc_reg);
            end
            swc_pkg::OP_SP_MR:
            begin
                mul_gain = cfg.spread_gain;
                mul_b    = dr_reg;
            end
            default:
            begin
                mul_gain = cfg.spread_gain;
                mul_b    = dl_reg;
            end
        endcase
    end

    assign prod     = $signed({1'b0, mul_gain}) * mul_b;
    assign accel    = -27'(p1_reg) - 27'(mul_reg);
    assign hit_diff = 25'(obj_x_reg) - 25'(cfg.left_edge);

    always_comb
    begin
        we      = 1'b0;
        h_we    = 1'b0;
        wa      = cmd.col[IW-1:0];
        h_wd    = hc_reg;
        v_wd    = vc_reg;
        ht_next = ht_reg;
        vt_next = vt_reg;
        if (!cmd.right)
        begin
            ht_next = swc_pkg::sat24(28'(ht_reg) + 28'(mul_reg));
            vt_next = swc_pkg::sat24(28'(vt_reg) + 28'(mul_reg));
        end
        unique case (cmd.op)
            swc_pkg::OP_S1_WR:
            begin
                we   = 1'b1;
                h_we = 1'b1;
                h_wd = swc_pkg::sat24(28'(hc_reg) + 28'(vc_reg));
                v_wd = swc_pkg::sat24(28'(vc_reg) + 28'(accel));
            end
            swc_pkg::OP_SP_WR:
            begin
                we   = 1'b1;
                h_we = 1'b1;
                h_wd = ht_next;
                v_wd = vt_next;
            end
            swc_pkg::OP_HIT_OUT:
            begin
                we   = struck_reg;
                wa   = hcol_reg;
                v_wd = cfg.splash_speed;
            end
            default: ;
        endcase
    end

    // column memories, written and read at most once a cycle
    always_ff @(posedge clk)
    begin
        if (h_we)
        begin
            hmem[wa] <= h_wd;
        end
        if (we)
        begin
            vmem[wa] <= v_wd;
        end
        if (cmd.op == swc_pkg::OP_READ)
        begin
            h_rd_reg  <= hmem[cmd.ha[IW-1:0]];
            hv_rd_reg <= hval_reg[cmd.ha[IW-1:0]];
            v_rd_reg  <= vmem[cmd.col[IW-1:0]];
            vv_rd_reg <= vval_reg[cmd.col[IW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hval_reg <= '0;
            vval_reg <= '0;
        end
        else
        begin
            if (h_we)
            begin
                hval_reg[wa] <= 1'b1;
            end
            if (we)
            begin
                vval_reg[wa] <= 1'b1;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        mul_reg <= prod[40:16];
        unique case (cmd.op)
            swc_pkg::OP_CAPTURE:
            begin
                obj_x_reg <= s_tdata[23:0];
                obj_y_reg <= s_tdata[47:24];
            end
            swc_pkg::OP_S1_LD:
            begin
                hc_reg <= hdat;
                vc_reg <= vdat;
                dl_reg <= 25'(hdat) - 25'(cfg.rest_height);
            end
            swc_pkg::OP_S1_MD:
            begin
                p1_reg <= mul_reg;
            end
            swc_pkg::OP_SP_HC:
            begin
                hc_reg <= hdat;
            end
            swc_pkg::OP_SP_LD:
            begin
                hn_reg <= hdat;
                vc_reg <= vdat;
                dl_reg <= 25'(hp_reg) - 25'(hc_reg);
                dr_reg <= 25'(hdat) - 25'(hc_reg);
            end
            swc_pkg::OP_SP_MR:
            begin
                // contribution of the left neighbor
                if (cmd.first)
                begin
                    ht_reg <= hc_reg;
                    vt_reg <= vc_reg;
                end
                else
                begin
                    ht_reg <= swc_pkg::sat24(28'(hc_reg) + 28'(mul_reg));
                    vt_reg <= swc_pkg::sat24(28'(vc_reg) + 28'(mul_reg));
                end
            end
            swc_pkg::OP_SP_WR:
            begin
                hp_reg <= hc_reg;
                hc_reg <= hn_reg;
            end
            swc_pkg::OP_HIT_INIT:
            begin
                rem_reg <= hit_diff[23:0];
            end
            swc_pkg::OP_HIT_STEP:
            begin
                if (!(rem_reg < {1'b0, cfg.column_width}) && (hcol_reg != IW'(RESOLUTION)))
                begin
                    rem_reg <= rem_reg - {1'b0, cfg.column_width};
                end
            end
            default: ;
        endcase
    end

    // column search by repeated subtraction of the width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hcol_reg     <= '0;
            hit_done_reg <= 1'b0;
            struck_reg   <= 1'b0;
        end
        else if (cmd.op == swc_pkg::OP_HIT_INIT)
        begin
            hcol_reg     <= '0;
            struck_reg   <= 1'b0;
            hit_done_reg <= !(obj_y_reg < cfg.rest_height) || (cfg.column_width == '0)
                            || hit_diff[24];
        end
        else if (cmd.op == swc_pkg::OP_HIT_STEP)
        begin
            if (rem_reg < {1'b0, cfg.column_width})
            begin
                hit_done_reg <= 1'b1;
                struck_reg   <= 1'b1;
            end
            else if (hcol_reg == IW'(RESOLUTION))
            begin
                hit_done_reg <= 1'b1;
            end
            else
            begin
                hcol_reg <= hcol_reg + 1'b1;
            end
        end
    end

    // output register
    assign load = (cmd.op == swc_pkg::OP_EMIT) || (cmd.op == swc_pkg::OP_HIT_OUT);

    always_comb
    begin
        if (cmd.op == swc_pkg::OP_EMIT)
        begin
            col_ext    = (IW + 5)'(cmd.col[IW-1:0]);
            out_height = hdat;
            out_hit    = 1'b0;
        end
        else
        begin
            col_ext    = struck_reg ? (IW + 5)'(hcol_reg) : '0;
            out_height = 24'sd0;
            out_hit    = struck_reg;
        end
        out_col = col_ext[4:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_height_reg <= out_height;
            out_col_reg    <= out_col;
            out_hit_reg    <= out_hit;
            out_last_reg   <= (cmd.op == swc_pkg::OP_HIT_OUT) || cmd.last;
        end
    end

    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = {3'b000, out_col_reg, out_height_reg};
    assign m_tuser       = out_hit_reg;
    assign m_tlast       = out_last_reg;
    assign stat.out_free = !out_valid_reg || m_tready;
    assign stat.hit_done = hit_done_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (load && out_valid_reg) |-> m_tready)
        else $error("output register overwritten before transfer");

    a_hit_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        hcol_reg <= IW'(RESOLUTION))
        else $error("hit search ran past the last column");

    a_struck_done: assert property (@(posedge clk) disable iff (!rst_n)
        struck_reg |-> hit_done_reg)
        else $error("column struck before search finished");

endmodule
`default_nettype wire

### rtl/spring_column_water_surface_unit.sv
// top level of the spring column water surface unit
//
//  channel   dir  handshake              payload
//  s_*       in   s_tvalid / s_tready    tdata obj_x, obj_y; tuser action
//  m_*       out  m_tvalid / m_tready    tdata height, column; tuser hit; tlast
//  apb       in   psel/penable/pready    seven registers at byte address 4*i
//
// a tick updates every column, runs SPREAD_PASSES spreading passes and emits every height,
// NCOL = RESOLUTION+1 heights in all, waiting on output stalls; the single shared gain
// multiplier and the one-port column memories make each pass walk the columns one by one
// a hit test subtracts one column width per cycle until it finds the struck column
// reset clears all heights and velocities at once through per-column valid bits
// input is taken only between items; a result waits in the output register
// while the next item is accepted
`default_nettype none
module spring_column_water_surface_unit #(
    parameter int RESOLUTION    = swc_pkg::RESOLUTION_DEF,
    parameter int SPREAD_PASSES = swc_pkg::SPREAD_PASSES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // input stream
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [47:0]                 s_tdata,   // obj_x[23:0], obj_y[47:24]
    input  wire logic                        s_tuser,   // action: 0 tick, 1 hit test
    // result stream
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [31:0]                      m_tdata,   // height[23:0], column[28:24], zero
    output logic                             m_tuser,   // hit
    output logic                             m_tlast,
    // configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [swc_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [swc_pkg::DATA_W-1:0]  pwdata,
    output logic      [swc_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);

    swc_pkg::cfg_t     cfg;
    swc_pkg::dp_cmd_t  cmd;
    swc_pkg::dp_stat_t stat;

    // configuration registers
    swc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: one input transfer at a time
    swc_ctrl #(
        .RESOLUTION    (RESOLUTION),
        .SPREAD_PASSES (SPREAD_PASSES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // column state, arithmetic and result register
    swc_dp #(
        .RESOLUTION (RESOLUTION)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

endmodule
`default_nettype wire
